// ===== rtl/tile_map_collision_mover_defines.svh =====
// ----------------------------------------------------------------------------
// tile map collision mover: assertion macros
// shared property forms for the mover's checks, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_COLLISION_MOVER_DEFINES_SVH
`define TILE_MAP_COLLISION_MOVER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TMCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcm: implication check failed");

// next-cycle implication
`define TMCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcm: next-cycle check failed");

// condition never holds
`define TMCM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> !(cond)) \
        else $error("tmcm: forbidden condition seen");

`else

`define TMCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TMCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define TMCM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/tmcm_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcm_pkg
// widths, codes, reset values and types of the tile map collision mover
// ----------------------------------------------------------------------------
package tmcm_pkg;

    // map and fixed point setup
    localparam int MAP_TILES  = 4096;
    localparam int TILE_SHIFT = 5;
    localparam int FRAC_BITS  = 8;
    localparam int MUL_SHIFT  = 8;
    localparam int TADDR_W    = $clog2(MAP_TILES);

    // field widths
    localparam int KIND_W        = 2;
    localparam int TADDR_FIELD_W = 12;
    localparam int TILE_W        = 10;
    localparam int ACC_W         = 2;
    localparam int POS_W         = 21;
    localparam int SPD_W         = 16;
    localparam int MAPDIM_W      = 7;
    localparam int STEP_W        = 8;
    localparam int FACT_W        = 9;
    localparam int HALF_W        = 13;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PLACE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_F  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF      = 3'd7;

    // register reset values
    localparam logic                RST_BOUNCE_EN = 1'b0;
    localparam logic [MAPDIM_W-1:0] RST_MAP_DIM   = 7'd64;
    localparam logic [TILE_W-1:0]   RST_TILE_CNT  = 10'd1023;
    localparam logic [STEP_W-1:0]   RST_ACCEL     = 8'd51;
    localparam logic [FACT_W-1:0]   RST_FRICTION  = 9'd253;
    localparam logic [FACT_W-1:0]   RST_BOUNCE_F  = 9'd230;
    localparam logic [HALF_W-1:0]   RST_HALF      = 13'd3277;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [SPD_W-1:0] t_spd;

    localparam t_pos POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam t_pos POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam t_spd SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam t_spd SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

endpackage

// ===== rtl/tmcm_in_if.sv =====
// ----------------------------------------------------------------------------
// tmcm_in_if
// input channel: tile write, tick and place words
// ----------------------------------------------------------------------------
interface tmcm_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [tmcm_pkg::KIND_W-1:0]             kind;
    logic [tmcm_pkg::TADDR_FIELD_W-1:0]      tile_addr;
    logic [tmcm_pkg::TILE_W-1:0]             tile_value;
    logic signed [tmcm_pkg::ACC_W-1:0]       accel_x;
    logic signed [tmcm_pkg::ACC_W-1:0]       accel_y;
    logic signed [tmcm_pkg::POS_W-1:0]       place_x;
    logic signed [tmcm_pkg::POS_W-1:0]       place_y;

    modport source (
        output valid, kind, tile_addr, tile_value, accel_x, accel_y, place_x, place_y,
        input  ready
    );
    modport sink (
        input  valid, kind, tile_addr, tile_value, accel_x, accel_y, place_x, place_y,
        output ready
    );
endinterface

// ===== rtl/tmcm_out_if.sv =====
// ----------------------------------------------------------------------------
// tmcm_out_if
// result channel: body position and hit flags after a tick
// ----------------------------------------------------------------------------
interface tmcm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tmcm_pkg::POS_W-1:0] out_x;
    logic signed [tmcm_pkg::POS_W-1:0] out_y;
    logic                              hit_x;
    logic                              hit_y;

    modport source (
        output valid, out_x, out_y, hit_x, hit_y,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, hit_x, hit_y,
        output ready
    );
endinterface

// ===== rtl/tmcm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tmcm_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface tmcm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tmcm_pkg::CFG_IDX_W-1:0]     index;
    logic [tmcm_pkg::CFG_DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/tmcm_ram.sv =====
// ----------------------------------------------------------------------------
// tmcm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tmcm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tile_map_collision_mover.sv =====
// ----------------------------------------------------------------------------
// tile_map_collision_mover
// moves one box body through a stored collision tile map, one tick per word
// ----------------------------------------------------------------------------
//  channel   dir  port    contents
//  input     in   i_in    kind, tile_addr, tile_value, accel_x/y, place_x/y
//  result    out  o_out   out_x, out_y, hit_x, hit_y (one word per tick)
//  register  in   i_cfg   index, data (always ready)
//
//  tile write and place words do not close the input; a tick word keeps it
//  closed through its scans, the bounce steps of each axis that bounces and friction.
//  the tick time comes from the eight corner reads through the single read
//  port of the tile ram (four per axis, one per cycle) and the one shared
//  speed scaling multiplier used for bounce and friction.
//  reset loads register reset values, clears body and speeds, not the tile ram.
//  a result waits in the output register while further words are accepted;
//  a tick that ends while that register is still full waits for it.
// ----------------------------------------------------------------------------
`include "tile_map_collision_mover_defines.svh"

module tile_map_collision_mover (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmcm_in_if.sink    i_in,
    tmcm_out_if.source o_out,
    tmcm_cfg_if.sink   i_cfg
);

    localparam int POS_W       = tmcm_pkg::POS_W;
    localparam int SPD_W       = tmcm_pkg::SPD_W;
    localparam int MAPDIM_W    = tmcm_pkg::MAPDIM_W;
    localparam int FRAC_BITS   = tmcm_pkg::FRAC_BITS;
    localparam int CAND_W      = POS_W + 1;
    localparam int CORNER_W    = POS_W + 2;
    localparam int COORD_SHIFT = tmcm_pkg::FRAC_BITS + tmcm_pkg::TILE_SHIFT;
    localparam int TC_W        = CORNER_W - COORD_SHIFT;
    localparam int CMP_W       = (TC_W > MAPDIM_W + 1) ? TC_W : MAPDIM_W + 1;
    localparam int ADDR_W      = 2 * MAPDIM_W;
    localparam int SUM_W       = SPD_W + 1;
    localparam int DV_W        = tmcm_pkg::STEP_W + 3;
    localparam int PROD_W      = SPD_W + 1 + tmcm_pkg::FACT_W;
    localparam int MAG_W       = PROD_W - tmcm_pkg::MUL_SHIFT;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ACC   = 4'd1;
    localparam logic [3:0] S_CAND  = 4'd2;
    localparam logic [3:0] S_PREP  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_BMUL  = 4'd6;
    localparam logic [3:0] S_BAPP  = 4'd7;
    localparam logic [3:0] S_FMUL  = 4'd8;
    localparam logic [3:0] S_FAPP  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    typedef struct packed {
        logic                oob;
        logic [MAPDIM_W-1:0] idx;
    } t_coord;

    function automatic tmcm_pkg::t_spd sat_spd(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1] != v[SUM_W-2]) begin
            return v[SUM_W-1] ? tmcm_pkg::SPD_MIN : tmcm_pkg::SPD_MAX;
        end
        return v[SPD_W-1:0];
    endfunction

    function automatic tmcm_pkg::t_pos sat_pos(input logic signed [CAND_W-1:0] v);
        if (v[CAND_W-1] != v[CAND_W-2]) begin
            return v[CAND_W-1] ? tmcm_pkg::POS_MIN : tmcm_pkg::POS_MAX;
        end
        return v[POS_W-1:0];
    endfunction

    // cut to a whole pixel toward zero
    function automatic tmcm_pkg::t_pos to_pixel(input tmcm_pkg::t_pos p);
        tmcm_pkg::t_pos dn;
        dn = {p[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
        if (p[POS_W-1] && (|p[FRAC_BITS-1:0])) begin
            dn = dn + tmcm_pkg::t_pos'(1 << FRAC_BITS);
        end
        return dn;
    endfunction

    // floor to tile coordinate, flag anything outside 0..lim-1
    function automatic t_coord to_tile(input logic signed [CORNER_W-1:0] c,
                                       input logic [MAPDIM_W-1:0] lim);
        logic signed [TC_W-1:0]  t;
        logic signed [CMP_W-1:0] te;
        t_coord                  r;
        t     = TC_W'(c >>> COORD_SHIFT);
        te    = CMP_W'(t);
        r.oob = te[CMP_W-1] || (unsigned'(te) >= CMP_W'(lim));
        r.idx = te[MAPDIM_W-1:0];
        return r;
    endfunction

    // registers
    logic                           r_bounce_en;
    logic [MAPDIM_W-1:0]            r_map_w;
    logic [MAPDIM_W-1:0]            r_map_h;
    logic [tmcm_pkg::TILE_W-1:0]    r_tile_count;
    logic [tmcm_pkg::STEP_W-1:0]    r_accel_step;
    logic [tmcm_pkg::FACT_W-1:0]    r_friction;
    logic [tmcm_pkg::FACT_W-1:0]    r_bounce_f;
    logic [tmcm_pkg::HALF_W-1:0]    r_half;

    // body state and sequencer
    logic [3:0]                     r_state;
    logic                           r_axis;
    logic [1:0]                     r_cnt;
    tmcm_pkg::t_pos                 r_body_x;
    tmcm_pkg::t_pos                 r_body_y;
    tmcm_pkg::t_spd                 r_spd_x;
    tmcm_pkg::t_spd                 r_spd_y;
    logic signed [tmcm_pkg::ACC_W-1:0] r_acc_x;
    logic signed [tmcm_pkg::ACC_W-1:0] r_acc_y;
    logic signed [CAND_W-1:0]       r_cand;
    logic [MAPDIM_W-1:0]            r_tx [2];
    logic [MAPDIM_W-1:0]            r_ty [2];
    logic [1:0]                     r_tx_oob;
    logic [1:0]                     r_ty_oob;
    logic                           r_chk_valid;
    logic                           r_chk_oob;
    logic                           r_hit;
    logic                           r_hit_x;
    logic                           r_hit_y;
    logic [PROD_W-1:0]              r_prod;
    logic                           r_neg;

    // result register
    logic                           r_out_valid;
    tmcm_pkg::t_pos                 r_out_x;
    tmcm_pkg::t_pos                 r_out_y;
    logic                           r_out_hx;
    logic                           r_out_hy;

    logic                           w_in_acc;
    logic                           w_ram_we;
    logic                           w_ram_re;
    logic [tmcm_pkg::TILE_W-1:0]    w_rdata;
    logic signed [DV_W-1:0]         w_step_s;
    logic signed [DV_W-1:0]         w_dvx;
    logic signed [DV_W-1:0]         w_dvy;
    tmcm_pkg::t_spd                 w_spd_sel;
    tmcm_pkg::t_pos                 w_pos_sel;
    logic signed [CAND_W-1:0]       w_cand;
    logic signed [CAND_W-1:0]       w_px;
    logic signed [CAND_W-1:0]       w_py;
    logic signed [CORNER_W-1:0]     w_h;
    t_coord                         w_txp;
    t_coord                         w_txm;
    t_coord                         w_typ;
    t_coord                         w_tym;
    logic                           w_ix;
    logic                           w_iy;
    logic [ADDR_W-1:0]              w_row;
    logic [ADDR_W-1:0]              w_addr;
    logic                           w_scan_oob;
    logic                           w_blk;
    logic                           w_hit;
    logic [tmcm_pkg::FACT_W-1:0]    w_mul_f;
    logic [SUM_W-1:0]               w_abs;
    logic [PROD_W-1:0]              w_prod;
    logic [MAG_W-1:0]               w_mag;
    logic signed [SPD_W-1:0]        w_mag_s;
    tmcm_pkg::t_spd                 w_lim_pos;
    tmcm_pkg::t_spd                 w_lim_neg;
    tmcm_pkg::t_spd                 w_bounce;
    tmcm_pkg::t_spd                 w_fric;
    logic                           w_out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_ram_we = w_in_acc && (i_in.kind == tmcm_pkg::KIND_WRITE)
                   && (32'(i_in.tile_addr) < tmcm_pkg::MAP_TILES);

    tmcm_ram #(
        .WIDTH (tmcm_pkg::TILE_W),
        .DEPTH (tmcm_pkg::MAP_TILES)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (tmcm_pkg::TADDR_W'(i_in.tile_addr)),
        .i_wdata (i_in.tile_value),
        .i_re    (w_ram_re),
        .i_raddr (tmcm_pkg::TADDR_W'(w_addr)),
        .o_rdata (w_rdata)
    );

    // key acceleration
    assign w_step_s = signed'(DV_W'(r_accel_step));
    assign w_dvx    = DV_W'(r_acc_x) * w_step_s;
    assign w_dvy    = DV_W'(r_acc_y) * w_step_s;

    // candidate position on the moving axis
    assign w_spd_sel = r_axis ? r_spd_y : r_spd_x;
    assign w_pos_sel = r_axis ? r_body_y : r_body_x;
    assign w_cand    = CAND_W'(w_pos_sel) + CAND_W'(w_spd_sel);

    // box corners in tile coordinates, index 0 is +half, 1 is -half
    assign w_px  = r_axis ? CAND_W'(r_body_x) : r_cand;
    assign w_py  = r_axis ? r_cand : CAND_W'(r_body_y);
    assign w_h   = signed'(CORNER_W'(r_half));
    assign w_txp = to_tile(CORNER_W'(w_px) + w_h, r_map_w);
    assign w_txm = to_tile(CORNER_W'(w_px) - w_h, r_map_w);
    assign w_typ = to_tile(CORNER_W'(w_py) + w_h, r_map_h);
    assign w_tym = to_tile(CORNER_W'(w_py) - w_h, r_map_h);

    // one corner per scan cycle
    assign w_ix       = r_cnt[0];
    assign w_iy       = r_cnt[1];
    assign w_row      = r_ty[w_iy] * r_map_w;
    assign w_addr     = w_row + ADDR_W'(r_tx[w_ix]);
    assign w_scan_oob = r_tx_oob[w_ix] || r_ty_oob[w_iy]
                     || (32'(w_addr) >= tmcm_pkg::MAP_TILES);
    assign w_ram_re   = (r_state == S_SCAN) && !w_scan_oob;

    assign w_blk = r_chk_valid && (r_chk_oob
                || ((w_rdata != '0) && (w_rdata < r_tile_count)));
    assign w_hit = r_hit || w_blk;

    // shared speed scaling: magnitude times factor, sign put back after
    assign w_mul_f = (r_state == S_BMUL) ? r_bounce_f : r_friction;
    assign w_abs   = w_spd_sel[SPD_W-1] ? SUM_W'(-(SUM_W'(w_spd_sel)))
                                        : SUM_W'(w_spd_sel);
    assign w_prod  = w_abs * w_mul_f;
    assign w_mag   = r_prod[PROD_W-1:tmcm_pkg::MUL_SHIFT];
    assign w_mag_s = w_mag[SPD_W-1:0];

    assign w_lim_pos = (w_mag > MAG_W'(tmcm_pkg::SPD_MAX)) ? tmcm_pkg::SPD_MAX : w_mag_s;
    assign w_lim_neg = (w_mag > MAG_W'(tmcm_pkg::SPD_MAX)) ? tmcm_pkg::SPD_MIN : -w_mag_s;
    assign w_bounce  = r_neg ? w_lim_pos : -w_lim_pos;
    assign w_fric    = r_neg ? w_lim_neg : w_lim_pos;

    assign w_out_free = !r_out_valid || o_out.ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce_en  <= tmcm_pkg::RST_BOUNCE_EN;
            r_map_w      <= tmcm_pkg::RST_MAP_DIM;
            r_map_h      <= tmcm_pkg::RST_MAP_DIM;
            r_tile_count <= tmcm_pkg::RST_TILE_CNT;
            r_accel_step <= tmcm_pkg::RST_ACCEL;
            r_friction   <= tmcm_pkg::RST_FRICTION;
            r_bounce_f   <= tmcm_pkg::RST_BOUNCE_F;
            r_half       <= tmcm_pkg::RST_HALF;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                tmcm_pkg::CFG_BOUNCE_EN: r_bounce_en  <= i_cfg.data[0];
                tmcm_pkg::CFG_MAP_W:     r_map_w      <= i_cfg.data[MAPDIM_W-1:0];
                tmcm_pkg::CFG_MAP_H:     r_map_h      <= i_cfg.data[MAPDIM_W-1:0];
                tmcm_pkg::CFG_TILE_CNT:  r_tile_count <= i_cfg.data[tmcm_pkg::TILE_W-1:0];
                tmcm_pkg::CFG_ACCEL:     r_accel_step <= i_cfg.data[tmcm_pkg::STEP_W-1:0];
                tmcm_pkg::CFG_FRICTION:  r_friction   <= i_cfg.data[tmcm_pkg::FACT_W-1:0];
                tmcm_pkg::CFG_BOUNCE_F:  r_bounce_f   <= i_cfg.data[tmcm_pkg::FACT_W-1:0];
                tmcm_pkg::CFG_HALF:      r_half       <= i_cfg.data[tmcm_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers with no reset
    always_ff @(posedge i_clk) begin
        r_chk_oob <= w_scan_oob;
        r_prod    <= w_prod;
        r_neg     <= w_spd_sel[SPD_W-1];
        if (r_state == S_CAND) begin
            r_cand <= w_cand;
        end
        if (r_state == S_PREP) begin
            r_tx[0]  <= w_txp.idx;
            r_tx[1]  <= w_txm.idx;
            r_ty[0]  <= w_typ.idx;
            r_ty[1]  <= w_tym.idx;
            r_tx_oob <= {w_txm.oob, w_txp.oob};
            r_ty_oob <= {w_tym.oob, w_typ.oob};
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_x  <= r_body_x;
            r_out_y  <= r_body_y;
            r_out_hx <= r_hit_x;
            r_out_hy <= r_hit_y;
        end
    end

    // sequencer and body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_body_x    <= '0;
            r_body_y    <= '0;
            r_spd_x     <= '0;
            r_spd_y     <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_chk_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_hit_x     <= 1'b0;
            r_hit_y     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chk_valid <= (r_state == S_SCAN);
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        priority if (i_in.kind == tmcm_pkg::KIND_PLACE) begin
                            r_body_x <= i_in.place_x;
                            r_body_y <= i_in.place_y;
                            r_spd_x  <= '0;
                            r_spd_y  <= '0;
                        end else if (i_in.kind == tmcm_pkg::KIND_TICK) begin
                            r_acc_x <= i_in.accel_x;
                            r_acc_y <= i_in.accel_y;
                            r_state <= S_ACC;
                        end else begin
                            // tile writes go straight to the ram, other codes do nothing
                        end
                    end
                end
                S_ACC: begin
                    r_spd_x <= sat_spd(SUM_W'(r_spd_x) + SUM_W'(w_dvx));
                    r_spd_y <= sat_spd(SUM_W'(r_spd_y) + SUM_W'(w_dvy));
                    r_axis  <= 1'b0;
                    r_state <= S_CAND;
                end
                S_CAND: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_hit   <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_hit <= w_hit;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_axis) begin
                        r_hit_y <= w_hit;
                    end else begin
                        r_hit_x <= w_hit;
                    end
                    if (!w_hit) begin
                        if (r_axis) begin
                            r_body_y <= sat_pos(r_cand);
                        end else begin
                            r_body_x <= sat_pos(r_cand);
                        end
                    end else if (!r_bounce_en) begin
                        if (r_axis) begin
                            r_body_y <= to_pixel(r_body_y);
                            r_spd_y  <= '0;
                        end else begin
                            r_body_x <= to_pixel(r_body_x);
                            r_spd_x  <= '0;
                        end
                    end
                    priority if (w_hit && r_bounce_en) begin
                        r_state <= S_BMUL;
                    end else if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_CAND;
                    end else begin
                        r_axis  <= 1'b0;
                        r_state <= S_FMUL;
                    end
                end
                S_BMUL: begin
                    r_state <= S_BAPP;
                end
                S_BAPP: begin
                    if (r_axis) begin
                        r_spd_y <= w_bounce;
                        r_axis  <= 1'b0;
                        r_state <= S_FMUL;
                    end else begin
                        r_spd_x <= w_bounce;
                        r_axis  <= 1'b1;
                        r_state <= S_CAND;
                    end
                end
                S_FMUL: begin
                    r_state <= S_FAPP;
                end
                S_FAPP: begin
                    if (r_axis) begin
                        r_spd_y <= w_fric;
                        r_state <= S_OUT;
                    end else begin
                        r_spd_x <= w_fric;
                        r_axis  <= 1'b1;
                        r_state <= S_FMUL;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_x = r_out_x;
    assign o_out.out_y = r_out_y;
    assign o_out.hit_x = r_out_hx;
    assign o_out.hit_y = r_out_hy;

    // checks
    `TMCM_ASSERT_NEVER(a_no_write_busy, i_clk, i_rst_n, w_ram_we && (r_state != S_IDLE))
    `TMCM_ASSERT_IMP(a_read_in_scan, i_clk, i_rst_n, w_ram_re, r_state == S_SCAN)
    `TMCM_ASSERT_IMP(a_chk_in_scan, i_clk, i_rst_n, r_chk_valid, (r_state == S_SCAN) || (r_state == S_DRAIN))
    `TMCM_ASSERT_NXT(a_tick_starts, i_clk, i_rst_n, w_in_acc && (i_in.kind == tmcm_pkg::KIND_TICK), r_state == S_ACC)

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tile map collision mover: a queue-fed driver
// sends tile writes, places, ticks and unused kinds, an in-bench model of the body works
// out each tick word, and the monitor compares it with the result channel
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int     TILE_BITS     = FRAC_BITS + TILE_SHIFT;
    localparam longint TILE_SPAN     = longint'(1) << TILE_BITS;
    localparam longint POS_LO        = POS_MIN;
    localparam longint POS_HI        = POS_MAX;
    localparam longint SPD_LO        = SPD_MIN;
    localparam longint SPD_HI        = SPD_MAX;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     MAX_REPORTS   = 40;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic [TADDR_FIELD_W-1:0] tile_addr;
        logic [TILE_W-1:0]        tile_value;
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        t_pos                     place_x;
        t_pos                     place_y;
    } mover_word_t;

    typedef struct {
        t_pos x;
        t_pos y;
        logic hit_x;
        logic hit_y;
    } body_state_t;

    logic i_clk;
    logic i_rst_n;

    tmcm_in_if  in_if ();
    tmcm_out_if out_if ();
    tmcm_cfg_if cfg_if ();

    tile_map_collision_mover i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // body model state and register copies
    logic [TILE_W-1:0] tile_mem [MAP_TILES];
    longint body_px, body_py, vel_x, vel_y;
    longint cfg_bounce, cfg_map_w, cfg_map_h, cfg_tile_cnt;
    longint cfg_accel, cfg_friction, cfg_bounce_f, cfg_half;

    mover_word_t word_q [$];
    body_state_t body_q [$];
    mover_word_t cur_word;
    int queued_words   = 0;
    int accepted_words = 0;
    int fail_count     = 0;
    int send_idle_pct  = 19;
    int recv_idle_pct  = 76;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit corner_hit(longint px, longint py);
        longint tx, ty, addr;
        tx = px >>> TILE_BITS;
        ty = py >>> TILE_BITS;
        if (tx < 0 || ty < 0 || tx >= cfg_map_w || ty >= cfg_map_h) return 1'b1;
        addr = ty * cfg_map_w + tx;
        if (addr >= MAP_TILES) return 1'b1;
        return tile_mem[addr] != '0 && longint'(tile_mem[addr]) < cfg_tile_cnt;
    endfunction

    function automatic bit box_hit(longint cx, longint cy);
        return corner_hit(cx + cfg_half, cy + cfg_half) ||
               corner_hit(cx - cfg_half, cy + cfg_half) ||
               corner_hit(cx + cfg_half, cy - cfg_half) ||
               corner_hit(cx - cfg_half, cy - cfg_half);
    endfunction

    // magnitude scaling, remainder dropped toward zero
    function automatic longint scale_speed(longint v, longint f);
        longint mag;
        mag = (((v < 0) ? -v : v) * f) >>> MUL_SHIFT;
        return clip((v < 0) ? -mag : mag, SPD_LO, SPD_HI);
    endfunction

    function automatic void settle_axis(inout longint p, inout longint v);
        longint keep;
        keep = ~((longint'(1) << FRAC_BITS) - 1);
        if (cfg_bounce != 0) begin
            v = clip(-scale_speed(v, cfg_bounce_f), SPD_LO, SPD_HI);
        end else begin
            v = 0;
            p = (p >= 0) ? (p & keep) : -((-p) & keep);
        end
    endfunction

    function automatic void apply_word(mover_word_t w);
        body_state_t r;
        case (w.kind)
            KIND_WRITE: begin
                tile_mem[w.tile_addr] = w.tile_value;
            end
            KIND_PLACE: begin
                body_px = w.place_x;
                body_py = w.place_y;
                vel_x   = 0;
                vel_y   = 0;
            end
            KIND_TICK: begin
                vel_x = clip(vel_x + longint'(w.accel_x) * cfg_accel, SPD_LO, SPD_HI);
                vel_y = clip(vel_y + longint'(w.accel_y) * cfg_accel, SPD_LO, SPD_HI);
                // x first, then y from the updated x
                r.hit_x = box_hit(body_px + vel_x, body_py);
                if (r.hit_x) settle_axis(body_px, vel_x);
                else body_px = clip(body_px + vel_x, POS_LO, POS_HI);
                r.hit_y = box_hit(body_px, body_py + vel_y);
                if (r.hit_y) settle_axis(body_py, vel_y);
                else body_py = clip(body_py + vel_y, POS_LO, POS_HI);
                vel_x = scale_speed(vel_x, cfg_friction);
                vel_y = scale_speed(vel_y, cfg_friction);
                r.x = t_pos'(body_px);
                r.y = t_pos'(body_py);
                body_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // stimulus helpers: unused fields carry random bits
    function automatic mover_word_t rand_word(logic [KIND_W-1:0] k);
        mover_word_t w;
        w.kind       = k;
        w.tile_addr  = $urandom;
        w.tile_value = $urandom;
        w.accel_x    = $urandom;
        w.accel_y    = $urandom;
        w.place_x    = $urandom;
        w.place_y    = $urandom;
        return w;
    endfunction

    function automatic void push_word(mover_word_t w);
        word_q.push_back(w);
        queued_words++;
    endfunction

    function automatic void add_write(int a, int v);
        mover_word_t w;
        w = rand_word(KIND_WRITE);
        w.tile_addr  = a[TADDR_FIELD_W-1:0];
        w.tile_value = v[TILE_W-1:0];
        push_word(w);
    endfunction

    function automatic void add_place(longint x, longint y);
        mover_word_t w;
        w = rand_word(KIND_PLACE);
        w.place_x = t_pos'(x);
        w.place_y = t_pos'(y);
        push_word(w);
    endfunction

    function automatic void add_tick(int ax, int ay);
        mover_word_t w;
        w = rand_word(KIND_TICK);
        w.accel_x = ax[ACC_W-1:0];
        w.accel_y = ay[ACC_W-1:0];
        push_word(w);
    endfunction

    function automatic int rand_tile();
        return ($urandom_range(0, 99) < 25) ? int'($urandom_range(1, 1023)) : 0;
    endfunction

    // mostly place-then-drive runs inside the map, some writes and noise
    function automatic void add_random(int n);
        int done, pick, len, kx, ky;
        done = 0;
        while (done < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                if (cfg_map_w > 0 && cfg_map_h > 0)
                    add_place($urandom_range(0, int'(cfg_map_w * TILE_SPAN) - 1),
                              $urandom_range(0, int'(cfg_map_h * TILE_SPAN) - 1));
                else
                    add_place($urandom, $urandom);
                len = $urandom_range(3, 25);
                kx  = $urandom_range(0, 3);
                ky  = $urandom_range(0, 3);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0) kx = $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0) ky = $urandom_range(0, 3);
                    add_tick(kx, ky);
                end
                done += len + 1;
            end else if (pick < 80) begin
                add_write($urandom_range(0, MAP_TILES - 1), rand_tile());
                done++;
            end else if (pick < 88) begin
                add_place($urandom, $urandom);
                done++;
            end else if (pick < 93) begin
                push_word(rand_word(KIND_UNUSED));
            end else begin
                add_tick($urandom_range(0, 3), $urandom_range(0, 3));
                done++;
            end
        end
    endfunction

    task automatic set_regs(input int b, input int w, input int h, input int tc,
                            input int ac, input int fr, input int bf, input int he);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_IDX_W-1:0]  idxs [8];
        vals = '{b, w, h, tc, ac, fr, bf, he};
        idxs = '{CFG_BOUNCE_EN, CFG_MAP_W, CFG_MAP_H, CFG_TILE_CNT,
                 CFG_ACCEL, CFG_FRICTION, CFG_BOUNCE_F, CFG_HALF};
        for (int i = 0; i < 8; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idxs[i];
            cfg_if.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_if.ready);
            case (idxs[i])
                CFG_BOUNCE_EN: cfg_bounce   = vals[i][0];
                CFG_MAP_W:     cfg_map_w    = vals[i][MAPDIM_W-1:0];
                CFG_MAP_H:     cfg_map_h    = vals[i][MAPDIM_W-1:0];
                CFG_TILE_CNT:  cfg_tile_cnt = vals[i][TILE_W-1:0];
                CFG_ACCEL:     cfg_accel    = vals[i][STEP_W-1:0];
                CFG_FRICTION:  cfg_friction = vals[i][FACT_W-1:0];
                CFG_BOUNCE_F:  cfg_bounce_f = vals[i][FACT_W-1:0];
                CFG_HALF:      cfg_half     = vals[i][HALF_W-1:0];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // every word taken and every tick word back, then let the block settle
    task automatic wait_idle();
        while (accepted_words != queued_words || body_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                apply_word(cur_word);
                accepted_words++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_word         = word_q.pop_front();
                    in_if.kind       <= cur_word.kind;
                    in_if.tile_addr  <= cur_word.tile_addr;
                    in_if.tile_value <= cur_word.tile_value;
                    in_if.accel_x    <= cur_word.accel_x;
                    in_if.accel_y    <= cur_word.accel_y;
                    in_if.place_x    <= cur_word.place_x;
                    in_if.place_y    <= cur_word.place_y;
                    in_if.valid      <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        body_state_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (body_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result word x=%0d y=%0d hit=%b%b",
                                 $time, out_if.out_x, out_if.out_y,
                                 out_if.hit_x, out_if.hit_y);
                end else begin
                    want = body_q.pop_front();
                    if (want.x !== out_if.out_x || want.y !== out_if.out_y ||
                        want.hit_x !== out_if.hit_x || want.hit_y !== out_if.hit_y) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch expected x=%0d y=%0d hit=%b%b, got x=%0d y=%0d hit=%b%b",
                                     $time, want.x, want.y, want.hit_x, want.hit_y,
                                     out_if.out_x, out_if.out_y, out_if.hit_x, out_if.hit_y);
                    end
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_WRITE;
        in_if.tile_addr  = '0;
        in_if.tile_value = '0;
        in_if.accel_x    = '0;
        in_if.accel_y    = '0;
        in_if.place_x    = '0;
        in_if.place_y    = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_BOUNCE_EN;
        cfg_if.data      = '0;
        body_px = 0;
        body_py = 0;
        vel_x   = 0;
        vel_y   = 0;
        cfg_bounce   = RST_BOUNCE_EN;
        cfg_map_w    = RST_MAP_DIM;
        cfg_map_h    = RST_MAP_DIM;
        cfg_tile_cnt = RST_TILE_CNT;
        cfg_accel    = RST_ACCEL;
        cfg_friction = RST_FRICTION;
        cfg_bounce_f = RST_BOUNCE_F;
        cfg_half     = RST_HALF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the tile ram has no reset: load all of it before any tick
        for (int a = 0; a < MAP_TILES; a++) add_write(a, rand_tile());

        // directed words on the reset register values
        push_word(rand_word(KIND_UNUSED));
        add_write(0, 1023);
        add_write(MAP_TILES - 1, 1);
        add_write(2080, 0);
        add_write(2081, 512);
        add_write(2111, 0);
        add_place(32 * TILE_SPAN + TILE_SPAN / 2, 32 * TILE_SPAN + TILE_SPAN / 2);
        add_tick(1, 1);
        add_tick(-1, -1);
        add_tick(0, 0);
        add_tick(-2, -2);
        add_tick(1, -2);
        // right map edge, then fully outside with truncation toward zero
        add_place(64 * TILE_SPAN - RST_HALF - 40, 32 * TILE_SPAN + TILE_SPAN / 2);
        add_tick(1, 0);
        add_tick(1, 0);
        add_place(-300, -1000);
        add_tick(-1, 1);
        add_place(POS_MAX, POS_MIN);
        add_tick(-2, 1);
        add_place(POS_MIN, POS_MAX);
        add_tick(1, -2);
        wait_idle();

        set_regs(1, 64, 64, 1023, 51, 253, 230, 3277);
        add_random(150);
        wait_idle();
        set_regs(0, 32, 48, 512, 255, 256, 256, 8191);
        add_random(130);
        wait_idle();

        send_idle_pct = 76;
        recv_idle_pct = 19;
        set_regs(1, 1, 64, 1, 255, 0, 0, 0);
        add_random(80);
        wait_idle();
        // empty map blocks everything: alternating keys pump both speeds to the rails
        set_regs(1, 0, 0, 0, 255, 256, 256, 100);
        add_place(0, 0);
        for (int i = 0; i < 100; i++) add_tick((i % 2) ? 1 : -2, (i % 2) ? -2 : 1);
        wait_idle();
        set_regs(0, 127, 32, 700, 0, 200, 128, 4000);
        add_random(40);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(1, 48, 40, 1023, 90, 250, 200, 2000);
        add_random(80);
        wait_idle();
        add_random(80);
        wait_idle();
        set_regs(0, 64, 64, 300, 128, 240, 256, 1500);
        add_random(80);
        wait_idle();

        if (fail_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #24_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, body_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tmcm_pkg.sv
rtl/tmcm_in_if.sv
rtl/tmcm_out_if.sv
rtl/tmcm_cfg_if.sv
rtl/tmcm_ram.sv
rtl/tile_map_collision_mover.sv
bench/tb_top.sv
